FILE: hw/rtl/sorted_insert_priority_queue_defines.svh
// assertion macros shared by the checker
`ifndef SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_DEFINES_SVH

// property checked outside reset
`define SIPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define SIPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/sipq_pkg.sv
`timescale 1ns / 1ps
package sipq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FIELD_W     = 16;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic exec;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

FILE: hw/rtl/sipq_ctrl.sv
`timescale 1ns / 1ps
module sipq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sipq_pkg::stat_t  stat,
  output sipq_pkg::cmd_t   cmd
);
  import sipq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/sipq_datapath.sv
`timescale 1ns / 1ps
module sipq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sipq_pkg::cmd_t                cmd,
  output sipq_pkg::stat_t               stat,
  input  logic                          operation,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_score,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_arrival,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_payload,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          out_valid,
  output logic [sipq_pkg::FIELD_W-1:0]  out_score,
  output logic [sipq_pkg::FIELD_W-1:0]  out_arrival,
  output logic [sipq_pkg::FIELD_W-1:0]  out_payload,
  output logic [1:0]                    status,
  output logic [sipq_pkg::CNT_W-1:0]    entry_count,
  output logic                          is_empty,
  output logic                          is_full
);
  import sipq_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // captured request
  logic               op_q;
  logic [FIELD_W-1:0] new_score, new_arrival, new_payload;

  // sorted entry cells, index 0 is the front
  logic [FIELD_W-1:0] sc [QUEUE_DEPTH];
  logic [FIELD_W-1:0] ar [QUEUE_DEPTH];
  logic [FIELD_W-1:0] pl [QUEUE_DEPTH];
  logic [CNT_W-1:0]   count;

  logic [QUEUE_DEPTH-1:0] sel;
  logic                   q_full, q_empty, do_enq, do_deq;
  logic [CNT_W-1:0]       count_next;

  // output is free when empty or being taken this cycle
  assign stat.out_free = !res_valid || res_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q        <= operation;
      new_score   <= item_score;
      new_arrival <= item_arrival;
      new_payload <= item_payload;
    end
  end

  assign q_full  = (count == DEPTH_C);
  assign q_empty = (count == '0);
  assign do_enq  = cmd.exec && (op_q == OP_ENQ) && !q_full;
  assign do_deq  = cmd.exec && (op_q == OP_DEQ) && !q_empty;

  // per-cell compare: at or past the insert point, within the filled region or the first free cell
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      sel[k] = ((CNT_W'(k) < count) && (sc[k] < new_score)) || (CNT_W'(k) == count);
    end
  end

  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + 1'b1;
    end else if (do_deq) begin
      count_next = count - 1'b1;
    end
  end

  // parallel shift of the cells
  always_ff @(posedge clk) begin
    if (do_enq) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        if (sel[k]) begin
          if (k > 0 && sel[(k > 0) ? k - 1 : 0]) begin
            sc[k] <= sc[(k > 0) ? k - 1 : 0];
            ar[k] <= ar[(k > 0) ? k - 1 : 0];
            pl[k] <= pl[(k > 0) ? k - 1 : 0];
          end else begin
            sc[k] <= new_score;
            ar[k] <= new_arrival;
            pl[k] <= new_payload;
          end
        end
      end
    end else if (do_deq) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        sc[k] <= sc[k + 1];
        ar[k] <= ar[k + 1];
        pl[k] <= pl[k + 1];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.exec) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_valid   <= do_deq;
      out_score   <= do_deq ? sc[0] : '0;
      out_arrival <= do_deq ? ar[0] : '0;
      out_payload <= do_deq ? pl[0] : '0;
      entry_count <= count_next;
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == DEPTH_C);
      if (op_q == OP_ENQ) begin
        status <= q_full ? ST_FULL : ST_OK;
      end else begin
        status <= q_empty ? ST_EMPTY : ST_OK;
      end
    end
  end

endmodule

FILE: hw/rtl/sorted_insert_priority_queue.sv
`timescale 1ns / 1ps
// a result is loaded into the result register by the execute step, which waits while a stalled result is held
// one transaction at a time (accept state, then execute state); input is not ready again until execute is done
// an insert compares all 32 entry cells in parallel and shifts those at or past the insert point in the execute cycle
// reset (rst, synchronous): queue empty, no result pending, input ready
module sorted_insert_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_score,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_arrival,
  input  logic [sipq_pkg::FIELD_W-1:0]  item_payload,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          out_valid,
  output logic [sipq_pkg::FIELD_W-1:0]  out_score,
  output logic [sipq_pkg::FIELD_W-1:0]  out_arrival,
  output logic [sipq_pkg::FIELD_W-1:0]  out_payload,
  output logic [1:0]                    status,
  output logic [sipq_pkg::CNT_W-1:0]    entry_count,
  output logic                          is_empty,
  output logic                          is_full
);
  import sipq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  sipq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry cells and result register
  sipq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .item_score   (item_score),
    .item_arrival (item_arrival),
    .item_payload (item_payload),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .out_valid    (out_valid),
    .out_score    (out_score),
    .out_arrival  (out_arrival),
    .out_payload  (out_payload),
    .status       (status),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule

FILE: hw/rtl/sipq_checker.sv
`timescale 1ns / 1ps
`include "sorted_insert_priority_queue_defines.svh"
module sipq_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [sipq_pkg::CNT_W-1:0]   entry_count,
  input logic                         is_empty,
  input logic                         is_full
);
  import sipq_pkg::*;

  // a stalled result stays offered
  `SIPQ_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  // a stalled result keeps its count
  `SIPQ_ASSERT(a_cnt_hold, res_valid && !res_ready |=> $stable(entry_count), "stalled count changed")
  // one transaction in flight at a time
  `SIPQ_ASSERT(a_one_busy, in_valid && in_ready |=> !in_ready, "input taken while busy")
  // flags agree with the count
  `SIPQ_ASSERT(a_flags, res_valid |-> (is_empty == (entry_count == '0)) && (is_full == (entry_count == CNT_W'(QUEUE_DEPTH))), "flags disagree with count")
  // reset leaves no result and an open input
  `SIPQ_ASSERT_ALWAYS(a_reset, rst |=> !res_valid && in_ready, "bad state after reset")

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .res_valid   (res_valid),
  .res_ready   (res_ready),
  .entry_count (entry_count),
  .is_empty    (is_empty),
  .is_full     (is_full)
);
